[design/bsm_pkg.sv]
// Package for the bounding sphere merge block.
// Holds the transaction payload types and fixed arithmetic constants.
// No dependencies.
package bsm_pkg;

  localparam int T_BITS = 30;
  localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic              first_of_set;
    logic signed [31:0] in_center_x;
    logic signed [31:0] in_center_y;
    logic signed [31:0] in_center_z;
    logic [30:0]        in_radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_center_x;
    logic signed [31:0] out_center_y;
    logic signed [31:0] out_center_z;
    logic [30:0]        out_radius;
    logic               radius_saturated;
  } out_t;

endpackage

[design/bounding_sphere_merge.sv]
// Running bounding sphere merge in signed fixed point.
// Uses bsm_pkg for the payload types and constants.
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall   in_data  (in_t)
// out      output     out_valid / out_stall out_data (out_t)
//
// A load goes straight to the output state. A merge first computes the squares on
// the shared multiplier and does the containment compare; a contained sphere ends
// there. Otherwise it runs the square root, the divider setup and the divide on the
// shared compare/subtract unit, then the center offsets and radius, and then hands
// out the result.
// Synchronous reset clears the accumulator to the origin with radius 1.0.
// in_stall is high from acceptance until the result is taken; out_stall holds it.
module bounding_sphere_merge import bsm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_MC   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [5:0] cnt;

  logic signed [31:0] ax, ay, az;
  logic [30:0]        ar;
  logic               sat;
  in_t                hold;

  logic signed [32:0] dx, dy, dz;
  logic signed [31:0] rd;
  logic [65:0]        prod, sum;
  logic [63:0]        rd2;
  logic [32:0]        root, len, divrem;
  logic [36:0]        rem;
  logic [30:0]        q, numsh;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  always_comb begin
    unique case (cnt[1:0])
      2'd0: mul_a = mag33(dx);
      2'd1: mul_a = mag33(dy);
      2'd2: mul_a = mag33(dz);
      default: mul_a = mag33(33'(rd));
    endcase
    mul_b = (state == S_MC) ? {2'b00, q} : mul_a;
    mul_p = {33'd0, mul_a} * {33'd0, mul_b};
  end

  // shared compare/subtract for root and divide steps
  logic [36:0] sub_a, sub_b;
  logic [37:0] sub_d;
  logic        ge;
  always_comb begin
    if (state == S_SQRT) begin
      sub_a = {rem[34:0], sum[65:64]};
      sub_b = {2'b00, root, 2'b01};
    end else begin
      sub_a = {3'd0, divrem, numsh[30]};
      sub_b = {4'd0, len};
    end
    sub_d = {1'b0, sub_a} - {1'b0, sub_b};
    ge    = !sub_d[37];
  end

  // center offset from registered product
  logic [63:0]        off_sum;
  logic [33:0]        off;
  logic signed [32:0] d_sel;
  logic signed [31:0] c_sel;
  logic [33:0]        c_new;
  always_comb begin
    off_sum = prod[63:0] + 64'(1 << (T_BITS - 1));
    off     = off_sum[63:T_BITS];
    unique case (cnt[1:0])
      2'd1: begin d_sel = dx; c_sel = ax; end
      2'd2: begin d_sel = dy; c_sel = ay; end
      default: begin d_sel = dz; c_sel = az; end
    endcase
    if (d_sel[32]) c_new = {{2{c_sel[31]}}, c_sel} - off;
    else           c_new = {{2{c_sel[31]}}, c_sel} + off;
  end

  logic [32:0] len_v;
  logic [34:0] a_v;
  logic [34:0] nr_sum;
  always_comb begin
    len_v  = (root == 33'd0) ? 33'd1 : root;
    a_v    = {2'b00, len_v} + 35'(rd);
    nr_sum = {2'b00, len} + {4'd0, ar} + {4'd0, hold.in_radius};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ax    <= '0;
      ay    <= '0;
      az    <= '0;
      ar    <= 31'(64'd1 << FRAC_BITS);
      sat   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            hold <= in_data;
            sat  <= 1'b0;
            if (in_data.first_of_set) begin
              ax    <= in_data.in_center_x;
              ay    <= in_data.in_center_y;
              az    <= in_data.in_center_z;
              ar    <= in_data.in_radius;
              state <= S_OUT;
            end else begin
              dx    <= {in_data.in_center_x[31], in_data.in_center_x} - {ax[31], ax};
              dy    <= {in_data.in_center_y[31], in_data.in_center_y} - {ay[31], ay};
              dz    <= {in_data.in_center_z[31], in_data.in_center_z} - {az[31], az};
              rd    <= $signed({1'b0, in_data.in_radius}) - $signed({1'b0, ar});
              cnt   <= '0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (cnt < 6'd4) prod <= mul_p;
          unique case (cnt)
            6'd1: sum <= prod;
            6'd2, 6'd3: sum <= sum + prod;
            6'd4: rd2 <= prod[63:0];
            default: ;
          endcase
          if (cnt == 6'd4) state <= S_CHK;
          cnt <= cnt + 6'd1;
        end
        S_CHK: begin
          if ({2'b00, rd2} >= sum) begin
            if (rd > 32'sd0) begin
              ax <= hold.in_center_x;
              ay <= hold.in_center_y;
              az <= hold.in_center_z;
              ar <= hold.in_radius;
            end
            state <= S_OUT;
          end else begin
            rem   <= '0;
            root  <= '0;
            // 33 digit pairs cover the 66-bit sum
            cnt   <= 6'd32;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem  <= ge ? sub_d[36:0] : sub_a;
          root <= {root[31:0], ge};
          sum  <= {sum[63:0], 2'b00};
          if (cnt == 6'd0) state <= S_PREP;
          cnt <= cnt - 6'd1;
        end
        S_PREP: begin
          len    <= len_v;
          divrem <= a_v[34:2];
          numsh  <= {a_v[1:0], 29'd0};
          q      <= '0;
          cnt    <= 6'd30;
          state  <= S_DIV;
        end
        S_DIV: begin
          divrem <= ge ? sub_d[32:0] : sub_a[32:0];
          q      <= {q[29:0], ge};
          numsh  <= {numsh[29:0], 1'b0};
          if (cnt == 6'd0) begin
            cnt   <= '0;
            state <= S_MC;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_MC: begin
          if (cnt < 6'd3) prod <= mul_p;
          unique case (cnt)
            6'd1: ax <= c_new[31:0];
            6'd2: ay <= c_new[31:0];
            6'd3: az <= c_new[31:0];
            default: ;
          endcase
          if (cnt == 6'd3) begin
            if (nr_sum[34:1] > {3'd0, RADIUS_MAX}) begin
              ar  <= RADIUS_MAX;
              sat <= 1'b1;
            end else begin
              ar <= nr_sum[31:1];
            end
            state <= S_OUT;
          end
          cnt <= cnt + 6'd1;
        end
        default: begin
          if (!out_stall) state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{out_center_x: ax, out_center_y: ay, out_center_z: az,
                       out_radius: ar, radius_saturated: sat};

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat |-> ar == RADIUS_MAX)
    else $error("saturation flag without clipped radius");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepted transaction");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> divrem < len)
    else $error("divider remainder out of range");

  a_len_nz: assert property (@(posedge clk) disable iff (rst)
    state == S_MC |-> len != 33'd0)
    else $error("zero distance in merge");

endmodule

[sim/testbench.sv]
// Testbench for bounding_sphere_merge: directed table then random transactions,
// checked against an in-bench fixed-point predictor. Depends on bsm_pkg.
`timescale 1ns / 100ps

module testbench;
  import bsm_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 1630;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #2 clk = ~clk;

  bounding_sphere_merge #(.FRAC_BITS(FRAC)) dut (.*);

  // predictor state
  logic signed [63:0] sph_x, sph_y, sph_z;
  logic [63:0] sph_r;
  out_t sphere_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_sat = 0;
  bit hold_req = 0;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] root, rem, trial;
    root = 0;
    rem = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [63:0] move_toward(logic signed [63:0] c,
      logic signed [63:0] d, logic [63:0] t);
    logic [63:0] m, off;
    m = mag64(d) * t;
    off = (m + (64'd1 << (T_BITS - 1))) >> T_BITS;
    return d < 0 ? c - $signed(off) : c + $signed(off);
  endfunction

  function automatic out_t merge_predict(in_t it);
    logic signed [63:0] ox, oy, oz, dx, dy, dz, rd;
    logic [63:0] orad, len, tq, nr;
    logic [127:0] dist2, rd2;
    out_t res;
    bit sat;
    ox = it.in_center_x;
    oy = it.in_center_y;
    oz = it.in_center_z;
    orad = {33'd0, it.in_radius};
    sat = 0;
    if (it.first_of_set) begin
      sph_x = ox; sph_y = oy; sph_z = oz; sph_r = orad;
    end else begin
      dx = ox - sph_x;
      dy = oy - sph_y;
      dz = oz - sph_z;
      dist2 = 128'(mag64(dx)) * mag64(dx) + 128'(mag64(dy)) * mag64(dy)
            + 128'(mag64(dz)) * mag64(dz);
      rd = $signed(orad) - $signed(sph_r);
      rd2 = 128'(mag64(rd)) * mag64(rd);
      if (rd2 >= dist2) begin
        if (rd > 0) begin
          sph_x = ox; sph_y = oy; sph_z = oz; sph_r = orad;
        end
      end else begin
        len = floor_sqrt(dist2);
        if (len == 0) len = 1;
        tq = ((len + rd) << (T_BITS - 1)) / len;
        sph_x = move_toward(sph_x, dx, tq);
        sph_y = move_toward(sph_y, dy, tq);
        sph_z = move_toward(sph_z, dz, tq);
        nr = (len + sph_r + orad) >> 1;
        if (nr > RADIUS_MAX) begin
          sph_r = RADIUS_MAX;
          sat = 1;
        end else begin
          sph_r = nr;
        end
      end
    end
    res.out_center_x = sph_x[31:0];
    res.out_center_y = sph_y[31:0];
    res.out_center_z = sph_z[31:0];
    res.out_radius = sph_r[30:0];
    res.radius_saturated = sat;
    return res;
  endfunction

  function automatic in_t mk(bit f, int x, int y, int z, logic [30:0] r);
    in_t it;
    it.first_of_set = f;
    it.in_center_x = x;
    it.in_center_y = y;
    it.in_center_z = z;
    it.in_radius = r;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? RADIUS_MAX : 31'd0;
      2: return 31'($urandom_range(0, 32'h0004_0000));
      default: return 31'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  // directed table; expected typed in where obvious, else from the predictor
  typedef struct {
    in_t  it;
    bit   has_exp;
    out_t exp;
  } dir_row_t;
  dir_row_t dir_tab[$];

  // valid stays high after the transaction; the caller drops it before a gap
  task automatic send(in_t it, bit has_exp, out_t exp);
    out_t pred;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = merge_predict(it);
    if (has_exp && pred !== exp)
      $display("%0t: table row disagrees with predictor exp=%h pred=%h", $time, exp, pred);
    sphere_q.push_back(has_exp ? exp : pred);
    if (pred.radius_saturated) n_sat++;
    n_sent++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sphere_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        out_t e;
        e = sphere_q.pop_front();
        if (out_data.out_center_x !== e.out_center_x ||
            out_data.out_center_y !== e.out_center_y ||
            out_data.out_center_z !== e.out_center_z ||
            out_data.out_radius !== e.out_radius ||
            out_data.radius_saturated !== e.radius_saturated) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
        n_got++;
      end
    end
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int mode;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      mode = $urandom_range(0, 9);
      out_stall <= (mode < 3) ? 1'b1 : (mode < 6) ? $urandom_range(0, 1) : 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    out_t e;
    in_t it;
    int left, burst;
    // after reset: unit sphere at the origin
    e = '{out_center_x: 0, out_center_y: 0, out_center_z: 0,
          out_radius: 31'd65536, radius_saturated: 1'b0};
    dir_tab.push_back('{mk(0, 0, 0, 0, 31'd0), 1, e});
    dir_tab.push_back('{mk(0, 0, 0, 0, 31'd131072), 1,
        '{0, 0, 0, 31'd131072, 1'b0}});
    dir_tab.push_back('{mk(0, 32'sh0001_0000, 0, 0, 31'd65536), 0, e});
    dir_tab.push_back('{mk(0, 32'sh0010_0000, 32'sh0010_0000, 0, 31'd65536), 0, e});
    dir_tab.push_back('{mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, RADIUS_MAX), 1,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, RADIUS_MAX, 1'b0}});
    dir_tab.push_back('{mk(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, RADIUS_MAX), 0, e});
    dir_tab.push_back('{mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0), 1,
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 1'b0}});
    dir_tab.push_back('{mk(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0), 0, e});
    dir_tab.push_back('{mk(1, 0, 0, 0, 31'd0), 1, '{0, 0, 0, 31'd0, 1'b0}});
    dir_tab.push_back('{mk(0, 0, 0, 0, 31'd0), 1, '{0, 0, 0, 31'd0, 1'b0}});
    dir_tab.push_back('{mk(0, 1, 0, 0, 31'd0), 0, e});
    dir_tab.push_back('{mk(0, -5, 3, -7, 31'd1), 0, e});
    dir_tab.push_back('{mk(1, 100, 200, 300, 31'd50), 1, '{100, 200, 300, 31'd50, 1'b0}});
    dir_tab.push_back('{mk(0, 120, 200, 300, 31'd10), 1, '{100, 200, 300, 31'd50, 1'b0}});
    dir_tab.push_back('{mk(0, 110, 200, 300, 31'd500), 1, '{110, 200, 300, 31'd500, 1'b0}});
    dir_tab.push_back('{mk(0, -32'sh0100_0000, 32'sh0100_0000, 0, 31'h0001_0000), 0, e});
    dir_tab.push_back('{mk(1, 32'h7FFF_FFFF, 0, 0, 31'h4000_0000), 0, e});
    dir_tab.push_back('{mk(0, 32'h8000_0000, 0, 0, 31'h4000_0000), 0, e});
    dir_tab.push_back('{mk(1, 0, 0, 0, 31'h5555_5555), 0, e});
    dir_tab.push_back('{mk(0, 32'h2AAA_AAAA, 32'h5555_5555, 32'hD555_5555, 31'h2AAA_AAAA), 0, e});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].has_exp, dir_tab[i].exp);

    left = N_RANDOM;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (left < 1300 && left > 1270) hold_req = 1;
      for (int b = 0; b < burst && left > 0; b++) begin
        // mostly sets of merges, each started by a load
        it = mk($urandom_range(0, 7) == 0, rand_coord(), rand_coord(), rand_coord(),
                rand_radius());
        send(it, 0, e);
        left--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    while (sphere_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d transactions, %0d results checked, %0d saturated merges",
             n_sent, n_got, n_sat);
    if (errors == 0 && sphere_q.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
